/* hw/rtl/tsb_pkg.sv */
package tsb_pkg;

    localparam int BANK_BYTES_DEF = 64;
    localparam int NUM_COPIES     = 3;

    // copy lanes, numbered as the write target select codes
    localparam int LANE_LIVE = 0;
    localparam int LANE_B    = 1;
    localparam int LANE_C    = 2;

    localparam logic [1:0] SEL_LIVE = 2'd0;
    localparam logic [1:0] SEL_B    = 2'd1;
    localparam logic [1:0] SEL_C    = 2'd2;

    localparam int         CNT_W     = 7;
    localparam logic [6:0] COUNT_MAX = 7'd127;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_READ   = 2'd1,
        OP_SCRUB  = 2'd2,
        OP_COMMIT = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_WALK,
        ST_DONE
    } t_state;

    typedef logic [NUM_COPIES-1:0][7:0] t_triple;

    typedef struct packed {
        logic [NUM_COPIES-1:0] wen;
        logic                  ren;
        t_triple               wdata;
    } t_mem_req;

    typedef struct packed {
        t_triple fixed;
        logic    repair;
        logic    triple;
    } t_vote;

endpackage

/* hw/rtl/tsb_bank.sv */
module tsb_bank #(
    parameter int BankBytes = tsb_pkg::BANK_BYTES_DEF,
    parameter int AddrW     = $clog2(BankBytes)
) (
    input  logic                 i_clk,
    input  tsb_pkg::t_mem_req    i_req,
    input  logic [AddrW-1:0]     i_waddr,
    input  logic [AddrW-1:0]     i_raddr,
    output tsb_pkg::t_triple     o_rdata
);
    import tsb_pkg::*;

    // all three copies of a byte share one word, one lane per copy
    t_triple r_mem [BankBytes];
    t_triple r_rdata;

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < NUM_COPIES; l++) begin
            if (i_req.wen[l]) begin
                r_mem[i_waddr][l] <= i_req.wdata[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ren) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/tsb_vote.sv */
module tsb_vote (
    input  tsb_pkg::t_triple i_word,
    output tsb_pkg::t_vote   o_vote
);
    import tsb_pkg::*;

    logic [7:0] a, b, c;

    assign a = i_word[LANE_LIVE];
    assign b = i_word[LANE_B];
    assign c = i_word[LANE_C];

    always_comb begin
        o_vote.fixed  = i_word;
        o_vote.repair = 1'b0;
        o_vote.triple = 1'b0;
        if (a == b && b == c) begin
            o_vote.fixed = i_word;
        end else if (a == b) begin
            o_vote.fixed[LANE_C] = a;
            o_vote.repair        = 1'b1;
        end else if (a == c) begin
            o_vote.fixed[LANE_B] = a;
            o_vote.repair        = 1'b1;
        end else if (b == c) begin
            o_vote.fixed[LANE_LIVE] = b;
            o_vote.repair           = 1'b1;
        end else begin
            // no majority: shadow b wins
            o_vote.fixed[LANE_LIVE] = b;
            o_vote.fixed[LANE_C]    = b;
            o_vote.triple           = 1'b1;
        end
    end

endmodule

/* hw/rtl/tsb_seq.sv */
module tsb_seq #(
    parameter int BankBytes = tsb_pkg::BANK_BYTES_DEF,
    parameter int AddrW     = $clog2(BankBytes)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [6:0]           i_cfg_used_bytes,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_opcode,
    input  logic [1:0]           i_copy_select,
    input  logic [5:0]           i_byte_index,
    input  logic [7:0]           i_write_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [7:0]           o_read_data,
    output logic [6:0]           o_repairs,
    output logic [6:0]           o_triple_faults,
    output tsb_pkg::t_mem_req    o_mem_req,
    output logic [AddrW-1:0]     o_mem_waddr,
    output logic [AddrW-1:0]     o_mem_raddr,
    input  tsb_pkg::t_triple     i_mem_rdata,
    input  tsb_pkg::t_vote       i_vote
);
    import tsb_pkg::*;

    localparam logic [AddrW-1:0] LAST_ADDR = AddrW'(BankBytes - 1);

    t_state           r_state, n_state;
    t_opcode          r_op, n_op;
    logic [AddrW-1:0] r_addr, n_addr;
    logic [AddrW-1:0] r_paddr, n_paddr;
    logic [6:0]       r_left, n_left;
    logic             r_pv, n_pv;
    logic             r_rd_ok, n_rd_ok;
    logic [7:0]       r_rd, n_rd;
    logic [6:0]       r_rep, n_rep;
    logic [6:0]       r_tri, n_tri;
    logic [6:0]       r_used, n_used;
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_out_rd, n_out_rd;
    logic [6:0]       r_out_rep, n_out_rep;
    logic [6:0]       r_out_tri, n_out_tri;

    logic             in_fire;
    logic             out_load;
    logic             in_range;
    logic [6:0]       span;
    logic [AddrW-1:0] idx_addr;

    function automatic logic [6:0] bump(input logic [6:0] v);
        return (v != COUNT_MAX) ? v + 7'd1 : COUNT_MAX;
    endfunction

    assign o_cfg_ready = 1'b1;
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_load    = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);
    assign in_range    = (int'(i_byte_index) < BankBytes);
    assign span        = (int'(r_used) > BankBytes) ? 7'(BankBytes) : r_used;
    assign idx_addr    = AddrW'(i_byte_index);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_addr == LAST_ADDR) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_fire) begin
                    case (t_opcode'(i_opcode))
                        OP_WRITE: n_state = ST_DONE;
                        OP_READ:  n_state = ST_READ;
                        default:  n_state = ST_WALK;
                    endcase
                end
            end
            ST_READ: n_state = ST_DONE;
            ST_WALK: begin
                if (r_left == 7'd0 && !r_pv) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_load) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // memory requests and handshake outputs
    always_comb begin
        o_in_ready        = (r_state == ST_IDLE);
        o_mem_req.wen     = '0;
        o_mem_req.ren     = 1'b0;
        o_mem_req.wdata   = '0;
        o_mem_waddr       = r_addr;
        o_mem_raddr       = r_addr;
        case (r_state)
            ST_CLEAR: begin
                o_mem_req.wen = '1;
            end
            ST_IDLE: begin
                if (in_fire && in_range) begin
                    o_mem_waddr = idx_addr;
                    o_mem_raddr = idx_addr;
                    o_mem_req.wdata = {NUM_COPIES{i_write_data}};
                    case (t_opcode'(i_opcode))
                        OP_WRITE: begin
                            case (i_copy_select)
                                SEL_LIVE: o_mem_req.wen[LANE_LIVE] = 1'b1;
                                SEL_B:    o_mem_req.wen[LANE_B]    = 1'b1;
                                SEL_C:    o_mem_req.wen[LANE_C]    = 1'b1;
                                default:  o_mem_req.wen            = '0;
                            endcase
                        end
                        OP_READ: o_mem_req.ren = 1'b1;
                        default: o_mem_req.ren = 1'b0;
                    endcase
                end
            end
            ST_WALK: begin
                o_mem_req.ren = (r_left != 7'd0);
                if (r_pv) begin
                    o_mem_waddr   = r_paddr;
                    o_mem_req.wen = '1;
                    o_mem_req.wdata = (r_op == OP_SCRUB) ? i_vote.fixed :
                                      {NUM_COPIES{i_mem_rdata[LANE_LIVE]}};
                end
            end
            default: o_mem_req.ren = 1'b0;
        endcase
    end

    // datapath
    always_comb begin
        n_op        = r_op;
        n_addr      = r_addr;
        n_paddr     = r_paddr;
        n_left      = r_left;
        n_pv        = 1'b0;
        n_rd_ok     = r_rd_ok;
        n_rd        = r_rd;
        n_rep       = r_rep;
        n_tri       = r_tri;
        n_used      = (i_cfg_valid && o_cfg_ready) ? i_cfg_used_bytes : r_used;
        n_out_valid = (r_out_valid && i_out_ready) ? 1'b0 : r_out_valid;
        n_out_rd    = r_out_rd;
        n_out_rep   = r_out_rep;
        n_out_tri   = r_out_tri;
        case (r_state)
            ST_CLEAR: n_addr = r_addr + AddrW'(1);
            ST_IDLE: begin
                if (in_fire) begin
                    n_op    = t_opcode'(i_opcode);
                    n_rd_ok = in_range;
                    n_rd    = '0;
                    n_rep   = '0;
                    n_tri   = '0;
                    n_addr  = '0;
                    n_left  = span;
                end
            end
            ST_READ: n_rd = r_rd_ok ? i_mem_rdata[LANE_LIVE] : 8'd0;
            ST_WALK: begin
                n_pv = (r_left != 7'd0);
                if (r_left != 7'd0) begin
                    n_paddr = r_addr;
                    n_addr  = r_addr + AddrW'(1);
                    n_left  = r_left - 7'd1;
                end
                if (r_pv && r_op == OP_SCRUB) begin
                    if (i_vote.repair) n_rep = bump(r_rep);
                    if (i_vote.triple) n_tri = bump(r_tri);
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_out_rd    = r_rd;
                    n_out_rep   = r_rep;
                    n_out_tri   = r_tri;
                end
            end
            default: n_pv = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_addr      <= '0;
            r_left      <= '0;
            r_pv        <= 1'b0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_left      <= n_left;
            r_pv        <= n_pv;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_paddr   <= n_paddr;
        r_rd_ok   <= n_rd_ok;
        r_rd      <= n_rd;
        r_rep     <= n_rep;
        r_tri     <= n_tri;
        r_out_rd  <= n_out_rd;
        r_out_rep <= n_out_rep;
        r_out_tri <= n_out_tri;
    end

    assign o_out_valid     = r_out_valid;
    assign o_read_data     = r_out_rd;
    assign o_repairs       = r_out_rep;
    assign o_triple_faults = r_out_tri;

endmodule

/* hw/rtl/tmr_byte_scrubber.sv */
// triple-redundant byte store with scrubbing. every byte lives three times (live, shadow b,
// shadow c) in one word of a single bank with one write port and one registered read port.
// a write goes straight to the result stage, while a read first waits on the registered
// read port; scrub and commit stream through the first min(used_bytes, BANK_BYTES) bytes
// at one byte per cycle (read, vote or copy, write back on the following cycle), and an empty
// region walks no bytes. after reset the bank is cleared to zero, one word per cycle; no
// input word is taken during that pass, though the region register can be written.
// each input word yields exactly one result word; a finished result sits in an output register
// until taken, and the next input word is taken once the current result has moved there.
// writes to shadow b or c are allowed for fault injection; out-of-range indices and copy
// select 3 are ignored, reads there return zero, and both counters saturate at 127
module tmr_byte_scrubber #(
    parameter int BANK_BYTES = tsb_pkg::BANK_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [6:0] i_cfg_used_bytes,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_opcode,
    input  logic [1:0] i_copy_select,
    input  logic [5:0] i_byte_index,
    input  logic [7:0] i_write_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_read_data,
    output logic [6:0] o_repairs,
    output logic [6:0] o_triple_faults
);
    import tsb_pkg::*;

    localparam int ADDR_W = $clog2(BANK_BYTES);

    t_mem_req          mem_req;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    t_triple           mem_rdata;
    t_vote             vote;

    // sequencer: handshakes, region register, walk counters, result register
    tsb_seq #(
        .BankBytes (BANK_BYTES),
        .AddrW     (ADDR_W)
    ) u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_used_bytes (i_cfg_used_bytes),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_opcode         (i_opcode),
        .i_copy_select    (i_copy_select),
        .i_byte_index     (i_byte_index),
        .i_write_data     (i_write_data),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_read_data      (o_read_data),
        .o_repairs        (o_repairs),
        .o_triple_faults  (o_triple_faults),
        .o_mem_req        (mem_req),
        .o_mem_waddr      (mem_waddr),
        .o_mem_raddr      (mem_raddr),
        .i_mem_rdata      (mem_rdata),
        .i_vote           (vote)
    );

    // the three copies, one lane each
    tsb_bank #(
        .BankBytes (BANK_BYTES),
        .AddrW     (ADDR_W)
    ) u_bank (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .i_waddr (mem_waddr),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // two-of-three vote on the word just read
    tsb_vote u_vote (
        .i_word (mem_rdata),
        .o_vote (vote)
    );

    // streaming read-back never hits the word being written back
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_req.ren && (mem_req.wen != '0)) |-> (mem_raddr != mem_waddr))
        else $error("read and write of the same bank word in one cycle");

    // block is busy right after taking a word
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken twice without finishing");

    // a read result never carries scrub counts
    a_read_no_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_read_data != 8'd0) |-> (o_repairs == 7'd0 && o_triple_faults == 7'd0))
        else $error("read data and scrub counts in one result");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import tsb_pkg::*;

    localparam int         BANK        = BANK_BYTES_DEF;
    localparam logic [1:0] SEL_NONE    = 2'd3;  // unused copy select, write must be dropped
    localparam int         QUIET_LIMIT = 2000;  // cycles with no handshake at all
    localparam int         SETTLE      = 80;    // longest word: a full walk and its result
    localparam int         PHASE_WORDS = 100;

    typedef struct {
        logic [7:0] read_data;
        logic [6:0] repairs;
        logic [6:0] triple_faults;
    } t_reply;

    // mirror of the three copies, votes on scrub and queues the reply per word
    class store_tracker;
        logic [7:0] live[BANK];
        logic [7:0] shadow_b[BANK];
        logic [7:0] shadow_c[BANK];
        logic [6:0] region;
        t_reply     pending[$];
        int         faults;

        function new();
            foreach (live[i]) begin
                live[i]     = 8'd0;
                shadow_b[i] = 8'd0;
                shadow_c[i] = 8'd0;
            end
            region = 7'd0;
            faults = 0;
        endfunction

        function void set_region(logic [6:0] v);
            region = v;
        endfunction

        function void take_word(t_opcode op, logic [1:0] sel, logic [5:0] idx,
                                logic [7:0] data);
            t_reply     r;
            int         span;
            logic [7:0] a, b, c;
            r.read_data     = 8'd0;
            r.repairs       = 7'd0;
            r.triple_faults = 7'd0;
            span = (int'(region) > BANK) ? BANK : int'(region);
            case (op)
                OP_WRITE: begin
                    if (int'(idx) < BANK) begin
                        case (sel)
                            SEL_LIVE: live[idx]     = data;
                            SEL_B:    shadow_b[idx] = data;
                            SEL_C:    shadow_c[idx] = data;
                            default:  ;
                        endcase
                    end
                end
                OP_READ: begin
                    if (int'(idx) < BANK) r.read_data = live[idx];
                end
                OP_SCRUB: begin
                    for (int i = 0; i < span; i++) begin
                        a = live[i];
                        b = shadow_b[i];
                        c = shadow_c[i];
                        if (a == b && b == c) continue;
                        if (a == b || a == c || b == c) begin
                            if (a == b) shadow_c[i] = a;
                            else if (a == c) shadow_b[i] = a;
                            else live[i] = b;
                            if (r.repairs != COUNT_MAX) r.repairs++;
                        end else begin
                            live[i]     = b;
                            shadow_c[i] = b;
                            if (r.triple_faults != COUNT_MAX) r.triple_faults++;
                        end
                    end
                end
                default: begin
                    for (int i = 0; i < span; i++) begin
                        shadow_b[i] = live[i];
                        shadow_c[i] = live[i];
                    end
                end
            endcase
            pending.push_back(r);
        endfunction

        function void check_reply(logic [7:0] rd, logic [6:0] rep, logic [6:0] tf);
            t_reply want;
            if (pending.size() == 0) begin
                $error("result word with nothing expected: read_data %0h", rd);
                faults++;
                return;
            end
            want = pending.pop_front();
            if (rd !== want.read_data) begin
                $error("read_data expected %0h actual %0h", want.read_data, rd);
                faults++;
            end
            if (rep !== want.repairs) begin
                $error("repairs expected %0d actual %0d", want.repairs, rep);
                faults++;
            end
            if (tf !== want.triple_faults) begin
                $error("triple_faults expected %0d actual %0d", want.triple_faults, tf);
                faults++;
            end
        endfunction
    endclass

    // clock, reset and block ports; the inputs are known from time zero
    logic       i_clk            = 1'b0;
    logic       i_rst_n          = 1'b0;
    logic       i_cfg_valid      = 1'b0;
    logic [6:0] i_cfg_used_bytes = 7'd0;
    logic       i_in_valid       = 1'b0;
    logic [1:0] i_opcode         = 2'd0;
    logic [1:0] i_copy_select    = 2'd0;
    logic [5:0] i_byte_index     = 6'd0;
    logic [7:0] i_write_data     = 8'd0;
    logic       i_out_ready      = 1'b0;
    logic       o_cfg_ready;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_read_data;
    logic [6:0] o_repairs;
    logic [6:0] o_triple_faults;

    store_tracker tracker;
    bit           calm;         // set for a stretch with no idling on either side
    int           words_sent;

    tmr_byte_scrubber dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_used_bytes (i_cfg_used_bytes),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_opcode         (i_opcode),
        .i_copy_select    (i_copy_select),
        .i_byte_index     (i_byte_index),
        .i_write_data     (i_write_data),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_read_data      (o_read_data),
        .o_repairs        (o_repairs),
        .o_triple_faults  (o_triple_faults)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // roughly a quarter of cycles idle, unless in the calm stretch
    function automatic bit take_break();
        return !calm && ($urandom_range(99) < 25);
    endfunction

    // protected span as the block sees it, oversized regions clipped to the bank
    function automatic int span_of(logic [6:0] v);
        return (int'(v) > BANK) ? BANK : int'(v);
    endfunction

    // mostly inside the protected span so that scrub and commit see the traffic
    function automatic logic [5:0] pick_index();
        int span;
        span = span_of(tracker.region);
        if (span > 0 && $urandom_range(3) != 0) return 6'($urandom_range(span - 1));
        return 6'($urandom_range(63));
    endfunction

    // result side: check every taken word, then pick ready for the next edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            tracker.check_reply(o_read_data, o_repairs, o_triple_faults);
        i_out_ready <= !take_break();
    end

    // one input word; valid stays up across back-to-back words with no gap
    task automatic send_word(t_opcode op, logic [1:0] sel, logic [5:0] idx, logic [7:0] data);
        if (take_break()) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while (take_break());
        end
        i_in_valid    <= 1'b1;
        i_opcode      <= op;
        i_copy_select <= sel;
        i_byte_index  <= idx;
        i_write_data  <= data;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.take_word(op, sel, idx, data);
        words_sent++;
    endtask

    // lower valid, then wait until every reply has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        while (tracker.pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_region(logic [6:0] v);
        i_cfg_valid      <= 1'b1;
        i_cfg_used_bytes <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.set_region(v);
        i_cfg_valid <= 1'b0;
    endtask

    // commit, corrupt a few copies (sometimes two at one byte), scrub, read back
    task automatic fault_round();
        int         hits;
        logic [5:0] idx;
        logic [1:0] sel;
        send_word(OP_COMMIT, 2'($urandom_range(3)), 6'($urandom_range(63)),
                  8'($urandom_range(255)));
        hits = $urandom_range(1, 4);
        repeat (hits) begin
            idx = pick_index();
            sel = 2'($urandom_range(2));
            send_word(OP_WRITE, sel, idx, 8'($urandom_range(255)));
            if ($urandom_range(9) < 3)
                send_word(OP_WRITE, (sel == SEL_C) ? SEL_LIVE : sel + 2'd1, idx,
                          8'($urandom_range(255)));
        end
        send_word(OP_SCRUB, 2'($urandom_range(3)), 6'($urandom_range(63)),
                  8'($urandom_range(255)));
        repeat ($urandom_range(1, 2))
            send_word(OP_READ, 2'($urandom_range(3)), pick_index(), 8'($urandom_range(255)));
    endtask

    task automatic noise_word();
        send_word(t_opcode'($urandom_range(3)), 2'($urandom_range(3)),
                  6'($urandom_range(63)), 8'($urandom_range(255)));
    endtask

    // watchdog: ends the run if nothing moves on any channel for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                    || (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_top failed");
        $finish;
    end

    initial begin
        int         stop_at;
        logic [6:0] region;
        tracker    = new();
        calm       = 1'b0;
        words_sent = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // full bank: one fault of each kind, then a clean rescrub
        write_region(7'd64);
        send_word(OP_READ,   SEL_LIVE, 6'd0,  8'h00);   // cleared at reset
        send_word(OP_WRITE,  SEL_LIVE, 6'd0,  8'hff);
        send_word(OP_WRITE,  SEL_LIVE, 6'd63, 8'h5a);
        send_word(OP_COMMIT, SEL_LIVE, 6'd0,  8'h00);
        send_word(OP_READ,   SEL_B,    6'd63, 8'hff);
        send_word(OP_WRITE,  SEL_B,    6'd5,  8'h11);   // shadow b odd one out
        send_word(OP_WRITE,  SEL_C,    6'd6,  8'h22);   // shadow c odd one out
        send_word(OP_WRITE,  SEL_LIVE, 6'd7,  8'h33);   // live odd one out
        send_word(OP_WRITE,  SEL_LIVE, 6'd8,  8'h44);
        send_word(OP_WRITE,  SEL_B,    6'd8,  8'h55);   // all three differ at byte 8
        send_word(OP_WRITE,  SEL_NONE, 6'd9,  8'h99);   // must be dropped
        send_word(OP_SCRUB,  SEL_LIVE, 6'd0,  8'h00);
        send_word(OP_SCRUB,  SEL_C,    6'd63, 8'hff);
        send_word(OP_READ,   SEL_LIVE, 6'd8,  8'h00);
        send_word(OP_READ,   SEL_LIVE, 6'd9,  8'h00);

        // oversized region behaves as the whole bank
        drain();
        write_region(7'd127);
        send_word(OP_WRITE,  SEL_LIVE, 6'd3,  8'ha5);
        send_word(OP_COMMIT, SEL_B,    6'd3,  8'h00);
        send_word(OP_WRITE,  SEL_B,    6'd3,  8'h5a);
        send_word(OP_WRITE,  SEL_C,    6'd3,  8'h0f);
        send_word(OP_SCRUB,  SEL_NONE, 6'd3,  8'h00);
        send_word(OP_READ,   SEL_LIVE, 6'd3,  8'h00);

        // empty region: scrub and commit touch nothing
        drain();
        write_region(7'd0);
        send_word(OP_WRITE,  SEL_B,    6'd0,  8'h12);
        send_word(OP_SCRUB,  SEL_LIVE, 6'd0,  8'h00);
        send_word(OP_COMMIT, SEL_LIVE, 6'd0,  8'h00);

        // small region: a fault past the end stays put
        drain();
        write_region(7'd4);
        send_word(OP_WRITE,  SEL_C,    6'd10, 8'h77);
        send_word(OP_WRITE,  SEL_LIVE, 6'd2,  8'h80);
        send_word(OP_SCRUB,  SEL_LIVE, 6'd0,  8'h00);
        send_word(OP_READ,   SEL_LIVE, 6'd2,  8'h00);

        // random phases, each under its own region size
        for (int ph = 0; ph < 7; ph++) begin
            drain();
            case (ph)
                0:       region = 7'd64;
                1:       region = 7'd127;
                2:       region = 7'($urandom_range(2, 63));
                3:       region = 7'd1;
                4:       region = 7'($urandom_range(65, 126));
                5:       region = 7'd0;
                default: region = 7'($urandom_range(1, 64));
            endcase
            write_region(region);
            calm    = (ph == 2);
            stop_at = words_sent + PHASE_WORDS;
            while (words_sent < stop_at) begin
                if ($urandom_range(9) < 7) fault_round();
                else repeat (5) noise_word();
            end
        end
        calm = 1'b0;

        drain();
        repeat (SETTLE) @(posedge i_clk);
        if (tracker.faults == 0 && tracker.pending.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

/* tmr_byte_scrubber.f */
hw/rtl/tsb_pkg.sv
hw/rtl/tsb_bank.sv
hw/rtl/tsb_vote.sv
hw/rtl/tsb_seq.sv
hw/rtl/tmr_byte_scrubber.sv
tb/tb_top.sv
